### sv/ctp_pkg.sv
`default_nettype none

package ctp_pkg;

  localparam int NAME_COUNT = 9;
  localparam int NAME_CHARS = 8;
  localparam int COLOR_W = 24;
  localparam int HEX_DIGITS = 6;

  typedef struct packed {
    logic [7:0] ch;
    logic       last;
  } char_item_t;

  typedef struct packed {
    logic               ok;
    logic [COLOR_W-1:0] color;
  } res_item_t;

  typedef struct packed {
    logic [2:0]            position;
    logic [NAME_COUNT-1:0] name_mask;
    logic [COLOR_W-1:0]    hex_value;
    logic [2:0]            digit_count;
    logic                  first_was_zero;
    logic                  bad_token;
  } ctp_state_t;

  localparam ctp_state_t STATE_RESET = '{
    position:       3'd0,
    name_mask:      {NAME_COUNT{1'b1}},
    hex_value:      '0,
    digit_count:    3'd0,
    first_was_zero: 1'b0,
    bad_token:      1'b0
  };

  // BLACK WHITE RED GREEN BLUE YELLOW CYAN MAGENTA GRAY, zero padded
  localparam logic [7:0] NAME_TEXT [NAME_COUNT][NAME_CHARS] = '{
    '{"B", "L", "A", "C", "K", 8'h00, 8'h00, 8'h00},
    '{"W", "H", "I", "T", "E", 8'h00, 8'h00, 8'h00},
    '{"R", "E", "D", 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
    '{"G", "R", "E", "E", "N", 8'h00, 8'h00, 8'h00},
    '{"B", "L", "U", "E", 8'h00, 8'h00, 8'h00, 8'h00},
    '{"Y", "E", "L", "L", "O", "W", 8'h00, 8'h00},
    '{"C", "Y", "A", "N", 8'h00, 8'h00, 8'h00, 8'h00},
    '{"M", "A", "G", "E", "N", "T", "A", 8'h00},
    '{"G", "R", "A", "Y", 8'h00, 8'h00, 8'h00, 8'h00}
  };

  localparam logic [3:0] NAME_LEN [NAME_COUNT] = '{
    4'd5, 4'd5, 4'd3, 4'd5, 4'd4, 4'd6, 4'd4, 4'd7, 4'd4
  };

  localparam logic [COLOR_W-1:0] NAME_COLOR [NAME_COUNT] = '{
    24'h000000, 24'hFFFFFF, 24'hFF0000, 24'h00FF00, 24'h0000FF,
    24'hFFFF00, 24'h00FFFF, 24'hFF00FF, 24'h808080
  };

endpackage

`default_nettype wire

### sv/ctp_char_step.sv
`default_nettype none

module ctp_char_step
  import ctp_pkg::*;
(
  input  var ctp_state_t state,
  input  var char_item_t item,
  output var ctp_state_t state_next,
  output var res_item_t  result
);

  function automatic logic [4:0] hex_digit(input logic [7:0] c);
    logic [4:0] r;
    r = 5'd16;
    if (c inside {["0":"9"]}) begin
      r = {1'b0, 4'(c - 8'h30)};
    end else if (c inside {["a":"f"]}) begin
      r = {1'b0, 4'(c - 8'h57)};
    end else if (c inside {["A":"F"]}) begin
      r = {1'b0, 4'(c - 8'h37)};
    end
    return r;
  endfunction

  logic [4:0] digit;
  logic [3:0] pos_plus;

  assign digit = hex_digit(item.ch);
  assign pos_plus = {1'b0, state.position} + 4'd1;

  always_comb begin
    state_next = state;
    for (int i = 0; i < NAME_COUNT; i++) begin
      state_next.name_mask[i] = state.name_mask[i] &&
                                ({1'b0, state.position} < NAME_LEN[i]) &&
                                (NAME_TEXT[i][state.position] == item.ch);
    end

    if (state.position == 3'd1 && state.first_was_zero &&
        (item.ch == "x" || item.ch == "X")) begin
      state_next.hex_value = '0;
      state_next.digit_count = 3'd0;
    end else if (!digit[4]) begin
      if (state.digit_count >= 3'(HEX_DIGITS)) begin
        state_next.bad_token = 1'b1;
      end else begin
        state_next.hex_value = {state.hex_value[COLOR_W-5:0], digit[3:0]};
        state_next.digit_count = state.digit_count + 3'd1;
      end
    end else begin
      state_next.bad_token = 1'b1;
    end

    if (state.position == 3'd0 && item.ch == "0") begin
      state_next.first_was_zero = 1'b1;
    end

    if (state.position != 3'd7) begin
      state_next.position = state.position + 3'd1;
    end
  end

  always_comb begin
    result.ok = 1'b0;
    result.color = '0;
    for (int i = 0; i < NAME_COUNT; i++) begin
      if (state_next.name_mask[i] && NAME_LEN[i] == pos_plus) begin
        result.ok = 1'b1;
        result.color = NAME_COLOR[i];
      end
    end
    if (!result.ok && !state_next.bad_token &&
        state_next.digit_count == 3'(HEX_DIGITS)) begin
      result.ok = 1'b1;
      result.color = state_next.hex_value;
    end
  end

endmodule

`default_nettype wire

### sv/color_token_parser_unit.sv
`default_nettype none

// Color token parser: takes one token character per transfer on the char
// channel and, on the character flagged last, delivers one result on the res
// channel: ok plus a 24-bit RGB value for an exact color name (BLACK, WHITE,
// RED, GREEN, BLUE, YELLOW, CYAN, MAGENTA, GRAY) or exactly six hex digits
// with an optional 0x/0X prefix; color is zero when ok is low. Characters are
// taken one per cycle while char_stall is low; a character passes an input
// register and then the match and shift logic, and a last character's result
// is loaded into the output register when that register is free, and is
// taken from there when res_stall is low. Parser state returns to reset after
// every token. Only a stalled result held in the output register slows the
// char channel, and only when the next last character reaches it.

module color_token_parser_unit
  import ctp_pkg::*;
(
  input  var logic       clk,
  input  var logic       rst,
  input  var logic       char_valid,
  output var logic       char_stall,
  input  var char_item_t char_item,
  output var logic       res_valid,
  input  var logic       res_stall,
  output var res_item_t  res_item
);

  logic       in_full;
  char_item_t in_q;
  ctp_state_t state;
  ctp_state_t state_next;
  res_item_t  result;
  logic       res_free;
  logic       fire;

  assign res_free = !res_valid || !res_stall;
  assign fire = in_full && (!in_q.last || res_free);
  assign char_stall = in_full && !fire;

  ctp_char_step u_step (
    .state      (state),
    .item       (in_q),
    .state_next (state_next),
    .result     (result)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      in_full <= 1'b0;
    end else if (!char_stall) begin
      in_full <= char_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (char_valid && !char_stall) begin
      in_q <= char_item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= STATE_RESET;
    end else if (fire) begin
      state <= in_q.last ? STATE_RESET : state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (res_free) begin
      res_valid <= fire && in_q.last;
    end
  end

  always_ff @(posedge clk) begin
    if (res_free && fire && in_q.last) begin
      res_item <= result;
    end
  end

endmodule

`default_nettype wire

### tb/ctp_color_checker.sv
module ctp_color_checker
  import ctp_pkg::*;
(
  input  var logic       clk,
  input  var logic       rst,
  input  var logic       char_valid,
  input  var logic       char_stall,
  input  var char_item_t char_item,
  input  var logic       res_valid,
  input  var logic       res_stall,
  input  var res_item_t  res_item,
  output int             fail_count,
  output int             pending
);

  ctp_state_t tok;
  res_item_t  color_q[$];

  initial begin
    tok = STATE_RESET;
    fail_count = 0;
    pending = 0;
  end

  function automatic void take_char(input char_item_t it);
    logic [2:0]            pos;
    logic [NAME_COUNT-1:0] hit;
    logic [4:0]            nib;
    res_item_t             r;
    pos = tok.position;
    hit = '0;
    for (int i = 0; i < NAME_COUNT; i++) begin
      if (tok.name_mask[i] && pos < NAME_LEN[i] && NAME_TEXT[i][pos] == it.ch) begin
        hit[i] = 1'b1;
      end
    end
    tok.name_mask = hit;

    if (it.ch >= "0" && it.ch <= "9") begin
      nib = 5'(it.ch - "0");
    end else if (it.ch >= "a" && it.ch <= "f") begin
      nib = 5'(it.ch - "a" + 8'd10);
    end else if (it.ch >= "A" && it.ch <= "F") begin
      nib = 5'(it.ch - "A" + 8'd10);
    end else begin
      nib = 5'd16;
    end

    // 0x / 0X prefix drops the leading zero digit
    if (pos == 3'd1 && tok.first_was_zero && (it.ch == "x" || it.ch == "X")) begin
      tok.hex_value = '0;
      tok.digit_count = '0;
    end else if (nib < 5'd16) begin
      if (tok.digit_count >= 3'(HEX_DIGITS)) begin
        tok.bad_token = 1'b1;
      end else begin
        tok.hex_value = {tok.hex_value[COLOR_W-5:0], nib[3:0]};
        tok.digit_count = tok.digit_count + 3'd1;
      end
    end else begin
      tok.bad_token = 1'b1;
    end

    if (pos == 3'd0 && it.ch == "0") begin
      tok.first_was_zero = 1'b1;
    end
    if (pos != 3'd7) begin
      tok.position = pos + 3'd1;
    end

    if (it.last) begin
      r = '0;
      for (int i = 0; i < NAME_COUNT; i++) begin
        if (hit[i] && NAME_LEN[i] == {1'b0, pos} + 4'd1) begin
          r.ok = 1'b1;
          r.color = NAME_COLOR[i];
        end
      end
      if (!r.ok && !tok.bad_token && tok.digit_count == 3'(HEX_DIGITS)) begin
        r.ok = 1'b1;
        r.color = tok.hex_value;
      end
      color_q.push_back(r);
      tok = STATE_RESET;
    end
  endfunction

  always @(posedge clk) begin
    res_item_t want;
    if (rst) begin
      tok = STATE_RESET;
      color_q.delete();
    end else begin
      if (char_valid && !char_stall) begin
        take_char(char_item);
      end
      if (res_valid && !res_stall) begin
        if (color_q.size() == 0) begin
          if (fail_count < 10) begin
            $display("unexpected result transfer: ok=%0b color=%06h",
                     res_item.ok, res_item.color);
          end
          fail_count++;
        end else begin
          want = color_q.pop_front();
          if (res_item.ok !== want.ok || res_item.color !== want.color) begin
            if (fail_count < 10) begin
              $display("result mismatch: expected ok=%0b color=%06h, got ok=%0b color=%06h",
                       want.ok, want.color, res_item.ok, res_item.color);
            end
            fail_count++;
          end
        end
      end
    end
    pending = color_q.size();
  end

endmodule

### tb/tb_color_token_parser_unit.sv
module tb_color_token_parser_unit;
  import ctp_pkg::*;

  logic       clk;
  logic       rst;
  logic       char_valid;
  logic       char_stall;
  char_item_t char_item;
  logic       res_valid;
  logic       res_stall;
  res_item_t  res_item;
  int         fail_count;
  int         pending;

  int         idle_pct;
  int         stall_pct;
  int         chars_sent;
  int         tokens_sent;
  logic [7:0] tok_chars[$];

  color_token_parser_unit dut (
    .clk       (clk),
    .rst       (rst),
    .char_valid(char_valid),
    .char_stall(char_stall),
    .char_item (char_item),
    .res_valid (res_valid),
    .res_stall (res_stall),
    .res_item  (res_item)
  );

  ctp_color_checker checker_i (
    .clk       (clk),
    .rst       (rst),
    .char_valid(char_valid),
    .char_stall(char_stall),
    .char_item (char_item),
    .res_valid (res_valid),
    .res_stall (res_stall),
    .res_item  (res_item),
    .fail_count(fail_count),
    .pending   (pending)
  );

  initial begin
    clk = 1'b0;
  end

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  always @(negedge clk) begin
    res_stall <= ($urandom_range(99) < stall_pct);
  end

  initial begin
    #4000000;
    $display("Test completed with failures");
    $finish;
  end

  function automatic logic [7:0] hex_char(input int v, input bit upper);
    if (v < 10) begin
      return 8'("0" + v);
    end
    return upper ? 8'("A" + v - 10) : 8'("a" + v - 10);
  endfunction

  task automatic send_char(input logic [7:0] ch, input logic last);
    @(negedge clk);
    while ($urandom_range(99) < idle_pct) begin
      char_valid <= 1'b0;
      @(negedge clk);
    end
    char_valid <= 1'b1;
    char_item <= '{ch: ch, last: last};
    do @(posedge clk); while (char_stall);
    chars_sent++;
  endtask

  task automatic emit_token();
    for (int k = 0; k < tok_chars.size(); k++) begin
      send_char(tok_chars[k], k == tok_chars.size() - 1);
    end
    tok_chars.delete();
    tokens_sent++;
  endtask

  task automatic put_text(input string s);
    for (int k = 0; k < s.len(); k++) begin
      tok_chars.push_back(s[k]);
    end
  endtask

  task automatic add_name(input int k);
    for (int j = 0; j < NAME_LEN[k]; j++) begin
      tok_chars.push_back(NAME_TEXT[k][j]);
    end
  endtask

  task automatic add_hex(input int n, input bit prefix);
    if (prefix) begin
      tok_chars.push_back("0");
      tok_chars.push_back($urandom_range(1) ? "x" : "X");
    end
    repeat (n) tok_chars.push_back(hex_char($urandom_range(15), $urandom_range(1)));
  endtask

  task automatic build_random_token();
    int sel;
    int n;
    int j;
    sel = $urandom_range(99);
    if (sel < 28) begin
      add_name($urandom_range(NAME_COUNT - 1));
    end else if (sel < 58) begin
      add_hex(HEX_DIGITS, $urandom_range(1));
    end else if (sel < 70) begin
      n = $urandom_range(8);
      if (n == HEX_DIGITS) n = 7;
      add_hex(n, $urandom_range(1));
    end else if (sel < 85) begin
      add_name($urandom_range(NAME_COUNT - 1));
      j = $urandom_range(tok_chars.size() - 1);
      case ($urandom_range(3))
        0: void'(tok_chars.pop_back());
        1: tok_chars.push_back(8'($urandom_range(32, 126)));
        2: tok_chars[j] = tok_chars[j] ^ 8'h20;
        default: tok_chars[j] = 8'($urandom_range(255));
      endcase
    end else begin
      n = $urandom_range(1, 10);
      repeat (n) begin
        case ($urandom_range(3))
          0: tok_chars.push_back(hex_char($urandom_range(15), $urandom_range(1)));
          1: tok_chars.push_back($urandom_range(1) ? "x" : "0");
          default: tok_chars.push_back(8'($urandom_range(255)));
        endcase
      end
    end
    if (tok_chars.size() == 0) begin
      tok_chars.push_back(8'($urandom_range(255)));
    end
  endtask

  initial begin
    string directed[$];
    rst = 1'b1;
    char_valid = 1'b0;
    char_item = '0;
    res_stall = 1'b0;
    idle_pct = 0;
    stall_pct = 0;
    chars_sent = 0;
    tokens_sent = 0;
    repeat (5) @(posedge clk);
    @(negedge clk) rst <= 1'b0;

    directed = '{"BLACK", "WHITE", "RED", "GREEN", "BLUE", "YELLOW", "CYAN",
                 "MAGENTA", "GRAY", "black", "REDD", "BLAC", "MAGENTAS",
                 "FFFFFF", "000000", "0x1a2B3c", "0XabcdEF", "0x", "0x1234567",
                 "12x456", "00x123", "x12345", "12345"};
    foreach (directed[k]) begin
      put_text(directed[k]);
      emit_token();
    end
    // zero byte and all-ones byte
    tok_chars.push_back(8'h00);
    emit_token();
    put_text("AB");
    tok_chars.push_back(8'hFF);
    put_text("CDE");
    emit_token();

    while (chars_sent < 450) begin
      case ((tokens_sent / 12) % 4)
        0: begin idle_pct = 0;  stall_pct = 0;  end
        1: begin idle_pct = 45; stall_pct = 0;  end
        2: begin idle_pct = 0;  stall_pct = 45; end
        default: begin idle_pct = 14; stall_pct = 14; end
      endcase
      build_random_token();
      emit_token();
    end

    @(negedge clk) char_valid <= 1'b0;
    while (pending != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (fail_count == 0 && pending == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
